/* hdl/bsq_pkg.sv */
// ----------------------------------------------------------------------------
// bsq_pkg
// Shared types and constants for the buffered serial queue engine.
// ----------------------------------------------------------------------------
package bsq_pkg;

    localparam int DEPTH_DEF = 128;
    localparam int BYTE_W    = 8;
    localparam int FILL_W    = 7;
    localparam int REQ_W     = 2;
    localparam int STAT_W    = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_HOST_TX   = 2'd0,
        REQ_LINE_RX   = 2'd1,
        REQ_TX_DONE   = 2'd2,
        REQ_HOST_READ = 2'd3
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_REJECT   = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic rd;
        logic load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } stat_t;

endpackage

/* hdl/buffered_serial_queue_engine_unit.sv */
// ----------------------------------------------------------------------------
// buffered_serial_queue_engine_unit
// Transmit and receive byte queues of DEPTH entries each (DEPTH-1 usable)
// with a transmit-busy flag. One request is handled at a time: a request
// accepted in the idle state is executed, the queue memory is then read,
// and the result is loaded into the output register once it is free; only
// then is the next request taken. The queue memory read is registered and
// follows the pointer update of the same request. The result register
// frees the input side: a new request is taken while a result still waits.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module buffered_serial_queue_engine_unit #(
    parameter int DEPTH = bsq_pkg::DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [bsq_pkg::REQ_W-1:0]    s_req_type,
    input  logic [bsq_pkg::BYTE_W-1:0]   s_data_byte,
    input  logic                         s_burst_first,
    input  logic                         s_burst_last,
    input  logic [bsq_pkg::BYTE_W-1:0]   s_burst_length,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [bsq_pkg::STAT_W-1:0]   m_status,
    output logic                         m_line_valid,
    output logic [bsq_pkg::BYTE_W-1:0]   m_line_byte,
    output logic                         m_read_valid,
    output logic [bsq_pkg::BYTE_W-1:0]   m_read_byte,
    output logic [bsq_pkg::FILL_W-1:0]   m_rx_fill,
    output logic [bsq_pkg::FILL_W-1:0]   m_tx_fill,
    output logic                         m_tx_busy_out
);
    import bsq_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    bsq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bsq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_req_type     (s_req_type),
        .s_data_byte    (s_data_byte),
        .s_burst_first  (s_burst_first),
        .s_burst_last   (s_burst_last),
        .s_burst_length (s_burst_length),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_line_valid   (m_line_valid),
        .m_line_byte    (m_line_byte),
        .m_read_valid   (m_read_valid),
        .m_read_byte    (m_read_byte),
        .m_rx_fill      (m_rx_fill),
        .m_tx_fill      (m_tx_fill),
        .m_tx_busy_out  (m_tx_busy_out)
    );

    // one request in flight: no new request right after one is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another is in flight");

    // a result never loads while the output register still holds one
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && m_valid) |-> m_ready)
        else $error("result register overwritten");

    // a byte to the line leaves the transmitter busy
    a_line_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_line_valid) |-> m_tx_busy_out)
        else $error("line byte without busy transmitter");

    // a returned read byte carries ok status and no line byte
    a_read_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_read_valid) |-> (m_status == ST_OK && !m_line_valid))
        else $error("read result with bad status or line byte");

endmodule

/* hdl/bsq_ctrl.sv */
// ----------------------------------------------------------------------------
// bsq_ctrl
// Sequencer: capture a request, execute it, read the queue memory, load the
// result register.
// ----------------------------------------------------------------------------
module bsq_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  bsq_pkg::stat_t  stat,
    output bsq_pkg::cmd_t   cmd
);
    import bsq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_READ;
            end
            S_READ: begin
                cmd.rd     = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                // hold until the result register is free
                cmd.load = stat.out_free;
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* hdl/bsq_datapath.sv */
// ----------------------------------------------------------------------------
// bsq_datapath
// Transmit and receive ring queues, pointers, busy and burst flags, and the
// result register.
// ----------------------------------------------------------------------------
module bsq_datapath #(
    parameter int DEPTH = bsq_pkg::DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  bsq_pkg::cmd_t                cmd,
    output bsq_pkg::stat_t               stat,
    input  logic [bsq_pkg::REQ_W-1:0]    s_req_type,
    input  logic [bsq_pkg::BYTE_W-1:0]   s_data_byte,
    input  logic                         s_burst_first,
    input  logic                         s_burst_last,
    input  logic [bsq_pkg::BYTE_W-1:0]   s_burst_length,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [bsq_pkg::STAT_W-1:0]   m_status,
    output logic                         m_line_valid,
    output logic [bsq_pkg::BYTE_W-1:0]   m_line_byte,
    output logic                         m_read_valid,
    output logic [bsq_pkg::BYTE_W-1:0]   m_read_byte,
    output logic [bsq_pkg::FILL_W-1:0]   m_rx_fill,
    output logic [bsq_pkg::FILL_W-1:0]   m_tx_fill,
    output logic                         m_tx_busy_out
);
    import bsq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = (AW > FILL_W) ? AW : FILL_W;
    localparam int SW = CW + 2;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [CW-1:0] ring_fill(input logic [AW-1:0] w,
                                                input logic [AW-1:0] r);
        logic [CW-1:0] wc;
        logic [CW-1:0] rc;
        wc = CW'(w);
        rc = CW'(r);
        return (w < r) ? (wc - rc + CW'(DEPTH)) : (wc - rc);
    endfunction

    logic [BYTE_W-1:0] tx_mem [DEPTH];
    logic [BYTE_W-1:0] rx_mem [DEPTH];

    // captured request
    req_t              req_reg;
    logic [BYTE_W-1:0] data_reg;
    logic              first_reg;
    logic              last_reg;
    logic [BYTE_W-1:0] blen_reg;

    logic [AW-1:0] tx_wptr_reg, tx_rptr_reg, rx_wptr_reg, rx_rptr_reg;
    logic          busy_reg, burst_reg;
    logic          pop_tx_reg, pop_rx_reg;
    logic [AW-1:0] pop_addr_reg;
    status_t       status_reg;
    logic [BYTE_W-1:0] tx_rdata_reg, rx_rdata_reg;

    logic              m_valid_reg;
    logic [STAT_W-1:0] m_status_reg;
    logic              m_line_valid_reg, m_read_valid_reg, m_busy_reg;
    logic [BYTE_W-1:0] m_line_byte_reg, m_read_byte_reg;
    logic [FILL_W-1:0] m_rx_fill_reg, m_tx_fill_reg;

    logic [CW-1:0] tx_fill_c, rx_fill_c;
    logic          tx_full, tx_empty, rx_full, rx_empty;
    logic          too_long, accept_c;
    logic          tx_push, rx_push, tx_pop, rx_pop;
    logic          busy_c, burst_c;
    status_t       status_c;

    always_comb begin
        tx_fill_c = ring_fill(tx_wptr_reg, tx_rptr_reg);
        rx_fill_c = ring_fill(rx_wptr_reg, rx_rptr_reg);
        tx_full   = (tx_fill_c == CW'(DEPTH - 1));
        tx_empty  = (tx_fill_c == '0);
        rx_full   = (rx_fill_c == CW'(DEPTH - 1));
        rx_empty  = (rx_fill_c == '0);
        too_long  = ((SW'(tx_fill_c) + SW'(blen_reg)) > SW'(DEPTH - 1));
        accept_c  = first_reg ? (!too_long && (blen_reg != '0)) : burst_reg;

        tx_push  = 1'b0;
        rx_push  = 1'b0;
        tx_pop   = 1'b0;
        rx_pop   = 1'b0;
        burst_c  = burst_reg;
        busy_c   = busy_reg;
        status_c = ST_OK;
        unique case (req_reg)
            REQ_HOST_TX: begin
                tx_push = accept_c && !tx_full;
                burst_c = last_reg ? 1'b0 : accept_c;
                // kick an idle transmitter at the end of a burst
                tx_pop  = last_reg && !busy_reg && (tx_push || !tx_empty);
                busy_c  = busy_reg || tx_pop;
                if (first_reg && too_long) begin
                    status_c = ST_REJECT;
                end
            end
            REQ_LINE_RX: begin
                rx_push = !rx_full;
                if (rx_full) begin
                    status_c = ST_OVERFLOW;
                end
            end
            REQ_TX_DONE: begin
                tx_pop = !tx_empty;
                busy_c = !tx_empty;
            end
            REQ_HOST_READ: begin
                rx_pop = !rx_empty;
                if (rx_empty) begin
                    status_c = ST_EMPTY;
                end
            end
        endcase
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg   <= req_t'(s_req_type);
            data_reg  <= s_data_byte;
            first_reg <= s_burst_first;
            last_reg  <= s_burst_last;
            blen_reg  <= s_burst_length;
        end
    end

    // queue memories: write on execute, registered read on the next cycle
    always_ff @(posedge aclk) begin
        if (cmd.exec && tx_push) begin
            tx_mem[tx_wptr_reg] <= data_reg;
        end
        if (cmd.rd) begin
            tx_rdata_reg <= tx_mem[pop_addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && rx_push) begin
            rx_mem[rx_wptr_reg] <= data_reg;
        end
        if (cmd.rd) begin
            rx_rdata_reg <= rx_mem[pop_addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            pop_addr_reg <= tx_pop ? tx_rptr_reg : rx_rptr_reg;
            status_reg   <= status_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_wptr_reg <= '0;
            tx_rptr_reg <= '0;
            rx_wptr_reg <= '0;
            rx_rptr_reg <= '0;
            busy_reg    <= 1'b0;
            burst_reg   <= 1'b0;
            pop_tx_reg  <= 1'b0;
            pop_rx_reg  <= 1'b0;
        end else if (cmd.exec) begin
            if (tx_push) begin
                tx_wptr_reg <= ptr_inc(tx_wptr_reg);
            end
            if (tx_pop) begin
                tx_rptr_reg <= ptr_inc(tx_rptr_reg);
            end
            if (rx_push) begin
                rx_wptr_reg <= ptr_inc(rx_wptr_reg);
            end
            if (rx_pop) begin
                rx_rptr_reg <= ptr_inc(rx_rptr_reg);
            end
            busy_reg   <= busy_c;
            burst_reg  <= burst_c;
            pop_tx_reg <= tx_pop;
            pop_rx_reg <= rx_pop;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_status_reg     <= status_reg;
            m_line_valid_reg <= pop_tx_reg;
            m_line_byte_reg  <= pop_tx_reg ? tx_rdata_reg : '0;
            m_read_valid_reg <= pop_rx_reg;
            m_read_byte_reg  <= pop_rx_reg ? rx_rdata_reg : '0;
            m_rx_fill_reg    <= rx_fill_c[FILL_W-1:0];
            m_tx_fill_reg    <= tx_fill_c[FILL_W-1:0];
            m_busy_reg       <= busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign stat.out_free = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_line_valid  = m_line_valid_reg;
    assign m_line_byte   = m_line_byte_reg;
    assign m_read_valid  = m_read_valid_reg;
    assign m_read_byte   = m_read_byte_reg;
    assign m_rx_fill     = m_rx_fill_reg;
    assign m_tx_fill     = m_tx_fill_reg;
    assign m_tx_busy_out = m_busy_reg;

endmodule

/* dv/tb_buffered_serial_queue_engine_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_buffered_serial_queue_engine_unit
// Self-checking bench for the transmit/receive byte queue engine. Requests
// are driven through the valid/ready input channel. Each accepted request is
// run through a behavioral copy of both queues and the busy flag. Every
// result leaving the block is compared field by field against the oldest
// predicted result. Directed requests cover the corner cases, and random
// burst, drain, fill and read sequences follow under varying back-pressure.
// ----------------------------------------------------------------------------
import bsq_pkg::*;

typedef struct {
    status_t           status;
    bit                line_valid;
    bit [BYTE_W-1:0]   line_byte;
    bit                read_valid;
    bit [BYTE_W-1:0]   read_byte;
    bit [FILL_W-1:0]   rx_fill;
    bit [FILL_W-1:0]   tx_fill;
    bit                tx_busy;
} bsq_result_t;

class bsq_scoreboard;
    bit [BYTE_W-1:0] tx_mem [DEPTH_DEF];
    bit [BYTE_W-1:0] rx_mem [DEPTH_DEF];
    int              tx_wr, tx_rd, rx_wr, rx_rd;
    bit              tx_busy, burst_open;
    bsq_result_t     expected_q[$];
    int              noted, checked, errors;
    int              rejects, overflows, empty_reads, line_bytes;

    function int tx_level();
        return (tx_wr + DEPTH_DEF - tx_rd) % DEPTH_DEF;
    endfunction

    function int rx_level();
        return (rx_wr + DEPTH_DEF - rx_rd) % DEPTH_DEF;
    endfunction

    function int step_ptr(int p);
        return (p + 1 == DEPTH_DEF) ? 0 : p + 1;
    endfunction

    // hand the next transmit byte to the line and mark the transmitter busy
    function bit [BYTE_W-1:0] pop_line();
        bit [BYTE_W-1:0] b;
        b = tx_mem[tx_rd];
        tx_rd = step_ptr(tx_rd);
        tx_busy = 1'b1;
        line_bytes++;
        return b;
    endfunction

    function void note_request(req_t kind, bit [BYTE_W-1:0] data, bit first, bit last,
                               bit [BYTE_W-1:0] blen);
        bsq_result_t r;
        r.status     = ST_OK;
        r.line_valid = 1'b0;
        r.line_byte  = '0;
        r.read_valid = 1'b0;
        r.read_byte  = '0;
        noted++;
        case (kind)
            REQ_HOST_TX: begin
                if (first) begin
                    if (int'(blen) > DEPTH_DEF - 1 - tx_level()) begin
                        burst_open = 1'b0;
                        r.status = ST_REJECT;
                        rejects++;
                    end else begin
                        burst_open = (blen != 0);
                    end
                end
                // drop bytes past a full queue
                if (burst_open && tx_level() < DEPTH_DEF - 1) begin
                    tx_mem[tx_wr] = data;
                    tx_wr = step_ptr(tx_wr);
                end
                if (last) begin
                    burst_open = 1'b0;
                    if (!tx_busy && tx_level() != 0) begin
                        r.line_valid = 1'b1;
                        r.line_byte  = pop_line();
                    end
                end
            end
            REQ_LINE_RX: begin
                if (rx_level() < DEPTH_DEF - 1) begin
                    rx_mem[rx_wr] = data;
                    rx_wr = step_ptr(rx_wr);
                end else begin
                    r.status = ST_OVERFLOW;
                    overflows++;
                end
            end
            REQ_TX_DONE: begin
                if (tx_level() != 0) begin
                    r.line_valid = 1'b1;
                    r.line_byte  = pop_line();
                end else begin
                    tx_busy = 1'b0;
                end
            end
            default: begin
                if (rx_level() != 0) begin
                    r.read_valid = 1'b1;
                    r.read_byte  = rx_mem[rx_rd];
                    rx_rd = step_ptr(rx_rd);
                end else begin
                    r.status = ST_EMPTY;
                    empty_reads++;
                end
            end
        endcase
        r.rx_fill = FILL_W'(rx_level());
        r.tx_fill = FILL_W'(tx_level());
        r.tx_busy = tx_busy;
        expected_q.push_back(r);
    endfunction

    function void compare(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_result(bsq_result_t got);
        bsq_result_t want;
        if (expected_q.size() == 0) begin
            $display("%0t: result with no request outstanding", $time);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        checked++;
        compare("status", want.status, got.status);
        compare("line_valid", want.line_valid, got.line_valid);
        compare("line_byte", want.line_byte, got.line_byte);
        compare("read_valid", want.read_valid, got.read_valid);
        compare("read_byte", want.read_byte, got.read_byte);
        compare("rx_fill", want.rx_fill, got.rx_fill);
        compare("tx_fill", want.tx_fill, got.tx_fill);
        compare("tx_busy_out", want.tx_busy, got.tx_busy);
    endfunction
endclass

module tb_buffered_serial_queue_engine_unit;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 610;

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [REQ_W-1:0]    s_req_type     = '0;
    logic [BYTE_W-1:0]   s_data_byte    = '0;
    logic                s_burst_first  = 1'b0;
    logic                s_burst_last   = 1'b0;
    logic [BYTE_W-1:0]   s_burst_length = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [STAT_W-1:0]   m_status;
    logic                m_line_valid;
    logic [BYTE_W-1:0]   m_line_byte;
    logic                m_read_valid;
    logic [BYTE_W-1:0]   m_read_byte;
    logic [FILL_W-1:0]   m_rx_fill;
    logic [FILL_W-1:0]   m_tx_fill;
    logic                m_tx_busy_out;

    bsq_scoreboard queue_sb = new();

    int idle_pct      = 0;
    int stall_pct     = 0;
    int holds_asked   = 0;
    int holds_done    = 0;
    int hold_left     = 0;
    int requests_sent = 0;
    int cycle_count   = 0;

    always #2 aclk = ~aclk;

    buffered_serial_queue_engine_unit DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_data_byte    (s_data_byte),
        .s_burst_first  (s_burst_first),
        .s_burst_last   (s_burst_last),
        .s_burst_length (s_burst_length),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_line_valid   (m_line_valid),
        .m_line_byte    (m_line_byte),
        .m_read_valid   (m_read_valid),
        .m_read_byte    (m_read_byte),
        .m_rx_fill      (m_rx_fill),
        .m_tx_fill      (m_tx_fill),
        .m_tx_busy_out  (m_tx_busy_out)
    );

    // both channels sampled with pre-edge values
    always @(posedge aclk) begin
        bsq_result_t got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got.status     = status_t'(m_status);
                got.line_valid = m_line_valid;
                got.line_byte  = m_line_byte;
                got.read_valid = m_read_valid;
                got.read_byte  = m_read_byte;
                got.rx_fill    = m_rx_fill;
                got.tx_fill    = m_tx_fill;
                got.tx_busy    = m_tx_busy_out;
                queue_sb.check_result(got);
            end
            if (s_valid && s_ready) begin
                queue_sb.note_request(req_t'(s_req_type), s_data_byte, s_burst_first,
                                      s_burst_last, s_burst_length);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off when one is asked for
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left == 0 && holds_done != holds_asked) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_request(req_t kind, logic [BYTE_W-1:0] data, logic first,
                                logic last, logic [BYTE_W-1:0] blen);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_req_type     <= kind;
        s_data_byte    <= data;
        s_burst_first  <= first;
        s_burst_last   <= last;
        s_burst_length <= blen;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
    endtask

    // hold the input idle until every noted request has its result back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (queue_sb.noted != requests_sent || queue_sb.expected_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic send_burst(int blen, int count);
        for (int i = 0; i < count; i++) begin
            send_request(REQ_HOST_TX, BYTE_W'($urandom_range(255)), i == 0, i == count - 1,
                         (i == 0) ? blen[BYTE_W-1:0] : BYTE_W'($urandom_range(255)));
        end
    endtask

    task automatic run_random(int target);
        int pick;
        int sel;
        int space;
        int blen;
        int count;
        while (requests_sent < target) begin
            pick  = $urandom_range(99);
            space = DEPTH_DEF - 1 - queue_sb.tx_level();
            if (pick < 32) begin
                sel = $urandom_range(99);
                if (sel < 65)      blen = $urandom_range(1, 8);
                else if (sel < 75) blen = space;
                else if (sel < 85) blen = space + 1;
                else if (sel < 95) blen = $urandom_range(255);
                else               blen = 0;
                if (blen == 0)          count = 1;
                else if (blen > space)  count = $urandom_range(1, 3);
                else                    count = blen;
                // mismatched item counts: overrun the length or cut it short
                sel = $urandom_range(99);
                if (sel < 15)      count = count + $urandom_range(1, 4);
                else if (sel < 25) count = $urandom_range(1, count);
                send_burst(blen, count);
            end else if (pick < 57) begin
                repeat ($urandom_range(1, 16))
                    send_request(REQ_TX_DONE, BYTE_W'($urandom_range(255)),
                                 1'($urandom_range(1)), 1'($urandom_range(1)),
                                 BYTE_W'($urandom_range(255)));
            end else if (pick < 71) begin
                count = ($urandom_range(19) == 0) ? DEPTH_DEF + 1 - queue_sb.rx_level()
                                                  : $urandom_range(1, 6);
                repeat (count)
                    send_request(REQ_LINE_RX, BYTE_W'($urandom_range(255)),
                                 1'($urandom_range(1)), 1'($urandom_range(1)),
                                 BYTE_W'($urandom_range(255)));
            end else if (pick < 86) begin
                count = ($urandom_range(9) == 0) ? queue_sb.rx_level() + 2
                                                 : $urandom_range(1, 6);
                repeat (count)
                    send_request(REQ_HOST_READ, BYTE_W'($urandom_range(255)),
                                 1'($urandom_range(1)), 1'($urandom_range(1)),
                                 BYTE_W'($urandom_range(255)));
            end else begin
                repeat ($urandom_range(1, 4))
                    send_request(req_t'($urandom_range(3)), BYTE_W'($urandom_range(255)),
                                 1'($urandom_range(1)), 1'($urandom_range(1)),
                                 BYTE_W'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        send_request(REQ_HOST_READ, 8'h00, 1'b0, 1'b0, 8'h00);  // read with nothing queued
        send_request(REQ_TX_DONE,   8'hFF, 1'b1, 1'b1, 8'hFF);  // complete with empty queue
        send_request(REQ_HOST_TX,   8'hFF, 1'b1, 1'b1, 8'h00);  // zero length: no byte queued
        send_request(REQ_HOST_TX,   8'h3C, 1'b0, 1'b0, 8'h05);  // no open burst: drop
        send_request(REQ_HOST_TX,   8'h77, 1'b1, 1'b0, 8'hFF);  // too long: reject
        send_request(REQ_HOST_TX,   8'h78, 1'b0, 1'b1, 8'h00);
        send_request(REQ_HOST_TX,   8'h00, 1'b1, 1'b0, 8'h03);
        send_request(REQ_HOST_TX,   8'hFF, 1'b0, 1'b0, 8'h00);
        send_request(REQ_HOST_TX,   8'hA5, 1'b0, 1'b1, 8'h00);  // idle line: start sending
        send_request(REQ_HOST_TX,   8'h5A, 1'b1, 1'b1, 8'h01);  // busy line: queue only
        repeat (4) send_request(REQ_TX_DONE, 8'h00, 1'b0, 1'b0, 8'h00);
        send_request(REQ_LINE_RX,   8'h00, 1'b0, 1'b0, 8'h00);
        send_request(REQ_LINE_RX,   8'hFF, 1'b1, 1'b1, 8'hFF);
        repeat (3) send_request(REQ_HOST_READ, 8'h00, 1'b0, 1'b0, 8'h00);
        // more bytes than the declared length all go in
        send_request(REQ_HOST_TX,   8'h11, 1'b1, 1'b0, 8'h02);
        send_request(REQ_HOST_TX,   8'h22, 1'b0, 1'b0, 8'h00);
        send_request(REQ_HOST_TX,   8'h33, 1'b0, 1'b0, 8'h00);
        send_request(REQ_HOST_TX,   8'h44, 1'b0, 1'b1, 8'h00);
        // one byte more than the free space
        send_request(REQ_HOST_TX,   8'h55, 1'b1, 1'b0, 8'd125);
        send_request(REQ_HOST_TX,   8'h66, 1'b0, 1'b1, 8'h00);
        drain_results();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 63; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 63; end
                default: begin idle_pct = 25; stall_pct = 25; end
            endcase
            if (ph == 0) begin
                run_random(requests_sent + PHASE_ITEMS / 2);
                holds_asked++;
                run_random(requests_sent + 40);
            end
            run_random(requests_sent + PHASE_ITEMS / 2);
            drain_results();
        end

        drain_results();
        repeat (16) @(posedge aclk);
        $display("summary: %0d requests, %0d results checked, %0d mismatches",
                 requests_sent, queue_sb.checked, queue_sb.errors);
        $display("summary: %0d bursts rejected, %0d rx overflows, %0d empty reads, %0d line bytes",
                 queue_sb.rejects, queue_sb.overflows, queue_sb.empty_reads,
                 queue_sb.line_bytes);
        if (queue_sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
